FILE: rtl/core/wss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wss_pkg
// Shared types and constants of the wheel speed and sensor frame telemetry block
// ----------------------------------------------------------------------------
package wss_pkg;

    localparam int COUNTER_BITS_DEF = 32;

    // shared serial divider geometry
    localparam int DIVIDEND_W = 32;
    localparam int DIVISOR_W  = 36;
    localparam int DIV_CNT_W  = 5;

    localparam logic [11:0] ACCEL_SCALE = 12'd2500;
    localparam logic [14:0] ACCEL_MAX   = 15'd32767;
    // ceil(2^38 / 1000), exact ms to s quotient for any 32-bit count
    localparam logic [28:0] SEC_RECIP   = 29'h10624DD3;
    localparam logic [3:0]  LEN_MIN     = 4'd7;
    localparam logic [3:0]  LEN_FULL    = 4'd8;
    localparam logic [7:0]  OBSTACLE_ON = 8'd1;

    // register reset values
    localparam logic [10:0] RST_FRAME_ID     = 11'd1111;
    localparam logic [15:0] RST_RPM_NUM      = 16'd30000;
    localparam logic [15:0] RST_STOP_TICKS   = 16'd5000;
    localparam logic [15:0] RST_SPEED_GAIN   = 16'd8030;
    localparam logic [11:0] RST_TEMP_ALERT   = 12'd300;
    localparam logic [15:0] RST_SOUND_ALERT  = 16'd520;
    localparam logic [15:0] RST_ACCEL_PERIOD = 16'd500;

    typedef enum logic [2:0] {
        REG_FRAME_ID     = 3'd0,
        REG_RPM_NUM      = 3'd1,
        REG_STOP_TICKS   = 3'd2,
        REG_SPEED_GAIN   = 3'd3,
        REG_TEMP_ALERT   = 3'd4,
        REG_SOUND_ALERT  = 3'd5,
        REG_ACCEL_PERIOD = 3'd6
    } reg_idx_t;

    typedef enum logic [1:0] {
        DIV_RPM   = 2'd0,
        DIV_ACCEL = 2'd1
    } div_sel_t;

    typedef struct packed {
        logic     latch;
        logic     arm;
        logic     rpm_zero;
        logic     rpm_store;
        logic     speed_store;
        logic     frame_dec;
        logic     div_start;
        div_sel_t div_sel;
        logic     acc_store;
        logic     idle_upd;
        logic     sec_load;
        logic     out_load;
    } wss_cmd_t;

    typedef struct packed {
        logic is_capture;
        logic armed;
        logic diff_ok;
        logic frame_ok;
        logic accel_due;
        logic div_done;
        logic out_full;
    } wss_status_t;

    typedef struct packed {
        logic [11:0]        temp_tenths;
        logic [11:0]        humidity_tenths;
        logic [7:0]         obstacle_state;
        logic [15:0]        sound_level;
        logic [7:0]         sequence_number;
        logic [15:0]        speed_tenths_kmh;
        logic signed [15:0] accel_tenths_mps2;
        logic [15:0]        wheel_rpm;
        logic [22:0]        idle_seconds;
        logic [2:0]         alert_flags;
    } wss_result_t;

endpackage

FILE: rtl/core/wss_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wss_if
// Channel interfaces: input items, result items and register writes
// ----------------------------------------------------------------------------
interface wss_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [31:0] capture_value;
    logic [10:0] frame_id;
    logic [3:0]  frame_length;
    logic [63:0] frame_payload;
    logic [31:0] now_ms;

    modport source (output valid, mode, capture_value, frame_id, frame_length,
                    frame_payload, now_ms, input ready);
    modport sink   (input valid, mode, capture_value, frame_id, frame_length,
                    frame_payload, now_ms, output ready);
endinterface

interface wss_out_if;
    logic               valid;
    logic               ready;
    logic [11:0]        temp_tenths;
    logic [11:0]        humidity_tenths;
    logic [7:0]         obstacle_state;
    logic [15:0]        sound_level;
    logic [7:0]         sequence_number;
    logic [15:0]        speed_tenths_kmh;
    logic signed [15:0] accel_tenths_mps2;
    logic [15:0]        wheel_rpm;
    logic [22:0]        idle_seconds;
    logic [2:0]         alert_flags;

    modport source (output valid, temp_tenths, humidity_tenths, obstacle_state,
                    sound_level, sequence_number, speed_tenths_kmh,
                    accel_tenths_mps2, wheel_rpm, idle_seconds, alert_flags,
                    input ready);
    modport sink   (input valid, temp_tenths, humidity_tenths, obstacle_state,
                    sound_level, sequence_number, speed_tenths_kmh,
                    accel_tenths_mps2, wheel_rpm, idle_seconds, alert_flags,
                    output ready);
endinterface

interface wss_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/wss_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wss_div
// Restoring serial divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module wss_div
    import wss_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  busy,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  dvs_reg;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIVISOR_W:0]    trial;

    // one shift and trial subtract per cycle
    always_comb
    begin
        trial     = {rem_reg, quo_reg[DIVIDEND_W-1]};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = DIV_CNT_W'(DIVIDEND_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = DIVISOR_W'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DIVISOR_W-1:0];
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // operands
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            dvs_reg <= divisor;
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: rtl/core/wss_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wss_dp
// Datapath: registers, capture pairing, frame decode, accel and idle time
// ----------------------------------------------------------------------------
module wss_dp
    import wss_pkg::*;
#(
    parameter int COUNTER_BITS = COUNTER_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  wss_cmd_t    cmd,
    output wss_status_t status,
    // input item
    input  logic        in_mode,
    input  logic [31:0] in_capture_value,
    input  logic [10:0] in_frame_id,
    input  logic [3:0]  in_frame_length,
    input  logic [63:0] in_frame_payload,
    input  logic [31:0] in_now_ms,
    // register writes
    input  logic        cfg_valid,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // result item
    output logic        out_valid,
    input  logic        out_ready,
    output wss_result_t out_result
);

    // configuration
    logic [10:0] cfg_id_reg;
    logic [15:0] cfg_num_reg, cfg_stop_reg, cfg_gain_reg, cfg_sound_reg, cfg_period_reg;
    logic [11:0] cfg_temp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_id_reg     <= RST_FRAME_ID;
            cfg_num_reg    <= RST_RPM_NUM;
            cfg_stop_reg   <= RST_STOP_TICKS;
            cfg_gain_reg   <= RST_SPEED_GAIN;
            cfg_temp_reg   <= RST_TEMP_ALERT;
            cfg_sound_reg  <= RST_SOUND_ALERT;
            cfg_period_reg <= RST_ACCEL_PERIOD;
        end
        else if (cfg_valid)
        begin
            case (reg_idx_t'(cfg_index))
                REG_FRAME_ID:     cfg_id_reg     <= cfg_data[10:0];
                REG_RPM_NUM:      cfg_num_reg    <= cfg_data;
                REG_STOP_TICKS:   cfg_stop_reg   <= cfg_data;
                REG_SPEED_GAIN:   cfg_gain_reg   <= cfg_data;
                REG_TEMP_ALERT:   cfg_temp_reg   <= cfg_data[11:0];
                REG_SOUND_ALERT:  cfg_sound_reg  <= cfg_data;
                REG_ACCEL_PERIOD: cfg_period_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // latched input item
    logic        mode_reg;
    logic [31:0] cap_reg, now_reg;
    logic [10:0] id_reg;
    logic [3:0]  len_reg;
    logic [63:0] pl_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            mode_reg <= in_mode;
            cap_reg  <= in_capture_value;
            id_reg   <= in_frame_id;
            len_reg  <= in_frame_length;
            pl_reg   <= in_frame_payload;
            now_reg  <= in_now_ms;
        end
    end

    // block state
    logic                    armed_reg;
    logic [COUNTER_BITS-1:0] first_reg;
    logic [15:0]             rpm_reg, speed_reg, prev_speed_reg;
    logic signed [15:0]      accel_reg;
    logic [31:0]             last_accel_reg, last_moving_reg, idle_ms_reg;
    logic [7:0]              seq_reg;

    // decoded frame values
    logic [11:0] temp_reg, hum_reg;
    logic [7:0]  obst_reg;
    logic [15:0] sound_reg;
    logic [2:0]  flags_reg;
    logic [27:0] prod_reg;
    logic        neg_reg;
    logic [22:0] sec_reg;

    // capture pairing
    logic [COUNTER_BITS-1:0] cap_m, diff;
    assign cap_m = cap_reg[COUNTER_BITS-1:0];
    assign diff  = cap_m - first_reg;

    // frame bytes and fields
    logic [7:0]  b0, b1, b2, b3, b4, b5, b6, b7;
    logic [11:0] temp_c, hum_c;
    logic [15:0] sound_c, mag_c;
    logic        neg_c;
    assign {b7, b6, b5, b4, b3, b2, b1, b0} = pl_reg;
    assign temp_c  = {1'b0, b0, 3'b000} + {3'b000, b0, 1'b0} + {4'b0000, b1};
    assign hum_c   = {1'b0, b2, 3'b000} + {3'b000, b2, 1'b0} + {4'b0000, b3};
    assign sound_c = {b6, b5};
    assign neg_c   = speed_reg < prev_speed_reg;
    assign mag_c   = neg_c ? (prev_speed_reg - speed_reg) : (speed_reg - prev_speed_reg);

    // acceleration timing
    logic [31:0] dt;
    logic [35:0] dt9;
    assign dt  = now_reg - last_accel_reg;
    assign dt9 = {dt, 3'b000} + {4'b0000, dt};

    // idle seconds by reciprocal multiplication
    logic [60:0] sec_prod;
    assign sec_prod = {29'd0, idle_ms_reg} * {32'd0, SEC_RECIP};

    // shared divider operands
    logic [DIVIDEND_W-1:0] div_a, div_q;
    logic [DIVISOR_W-1:0]  div_b;
    logic                  div_busy, div_done;

    always_comb
    begin
        case (cmd.div_sel)
            DIV_RPM:
            begin
                div_a = {16'd0, cfg_num_reg};
                div_b = {20'd0, diff[15:0]};
            end
            DIV_ACCEL:
            begin
                div_a = {4'd0, prod_reg};
                div_b = dt9;
            end
            default:
            begin
                div_a = {16'd0, cfg_num_reg};
                div_b = {20'd0, diff[15:0]};
            end
        endcase
    end

    wss_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    // speed product and saturated acceleration
    logic [31:0]        speed_prod;
    logic [15:0]        acc_mag;
    logic signed [15:0] acc_c;
    assign speed_prod = rpm_reg * cfg_gain_reg;
    assign acc_mag    = (div_q > {17'd0, ACCEL_MAX}) ? {1'b0, ACCEL_MAX} : div_q[15:0];
    assign acc_c      = neg_reg ? -$signed(acc_mag) : $signed(acc_mag);

    // state updates
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg       <= 1'b0;
            first_reg       <= '0;
            rpm_reg         <= '0;
            speed_reg       <= '0;
            prev_speed_reg  <= '0;
            accel_reg       <= '0;
            last_accel_reg  <= '0;
            last_moving_reg <= '0;
            idle_ms_reg     <= '0;
            seq_reg         <= '0;
        end
        else
        begin
            if (cmd.arm)
            begin
                armed_reg <= 1'b1;
                first_reg <= cap_m;
            end
            if (cmd.rpm_zero)
            begin
                rpm_reg <= '0;
            end
            if (cmd.rpm_store)
            begin
                rpm_reg <= div_q[15:0];
            end
            if (cmd.speed_store)
            begin
                speed_reg <= speed_prod[31:16];
                armed_reg <= 1'b0;
                first_reg <= '0;
            end
            if (cmd.frame_dec && len_reg >= LEN_FULL)
            begin
                seq_reg <= b7;
            end
            if (cmd.acc_store)
            begin
                accel_reg      <= acc_c;
                prev_speed_reg <= speed_reg;
                last_accel_reg <= now_reg;
            end
            if (cmd.idle_upd)
            begin
                if (rpm_reg == '0)
                begin
                    idle_ms_reg <= now_reg - last_moving_reg;
                end
                else
                begin
                    idle_ms_reg     <= '0;
                    last_moving_reg <= now_reg;
                end
            end
        end
    end

    // frame decode registers
    always_ff @(posedge clk)
    begin
        if (cmd.frame_dec)
        begin
            temp_reg     <= temp_c;
            hum_reg      <= hum_c;
            obst_reg     <= b4;
            sound_reg    <= sound_c;
            flags_reg[0] <= (b4 == OBSTACLE_ON);
            flags_reg[1] <= (sound_c > cfg_sound_reg);
            flags_reg[2] <= (temp_c > cfg_temp_reg);
            prod_reg     <= 28'(mag_c) * 28'(ACCEL_SCALE);
            neg_reg      <= neg_c;
        end
        if (cmd.sec_load)
        begin
            sec_reg <= sec_prod[60:38];
        end
    end

    // result register
    logic        out_valid_reg;
    wss_result_t res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            res_reg.temp_tenths       <= temp_reg;
            res_reg.humidity_tenths   <= hum_reg;
            res_reg.obstacle_state    <= obst_reg;
            res_reg.sound_level       <= sound_reg;
            res_reg.sequence_number   <= seq_reg;
            res_reg.speed_tenths_kmh  <= speed_reg;
            res_reg.accel_tenths_mps2 <= accel_reg;
            res_reg.wheel_rpm         <= rpm_reg;
            res_reg.idle_seconds      <= sec_reg;
            res_reg.alert_flags       <= flags_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_result = res_reg;

    // status to controller
    assign status.is_capture = !mode_reg;
    assign status.armed      = armed_reg;
    assign status.diff_ok    = (diff != '0) && (diff < COUNTER_BITS'(cfg_stop_reg));
    assign status.frame_ok   = (id_reg == cfg_id_reg) && (len_reg >= LEN_MIN);
    assign status.accel_due  = (dt != '0) && (dt >= {16'd0, cfg_period_reg});
    assign status.div_done   = div_done;
    assign status.out_full   = out_valid_reg;

    // checks
    a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !div_busy)
        else $error("divider started while busy");
    a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !out_valid_reg)
        else $error("result register overwritten");
    a_accel_symmetric: assert property (@(posedge clk) disable iff (!rst_n)
        accel_reg != 16'sh8000)
        else $error("acceleration outside saturation range");
    a_rpm_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rpm_store |-> div_done)
        else $error("rpm stored without divider result");

endmodule

FILE: rtl/core/wss_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wss_ctrl
// Controller: sequences capture and frame processing over the datapath
// ----------------------------------------------------------------------------
module wss_ctrl
    import wss_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  wss_status_t status,
    output wss_cmd_t    cmd
);

    typedef enum logic [8:0] {
        S_IDLE      = 9'b000000001,
        S_DECODE    = 9'b000000010,
        S_RPM_DIV   = 9'b000000100,
        S_SPEED     = 9'b000001000,
        S_ACC_START = 9'b000010000,
        S_ACC_DIV   = 9'b000100000,
        S_IDLE_UPD  = 9'b001000000,
        S_SEC       = 9'b010000000,
        S_OUT       = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    // next state and commands
    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.div_sel = DIV_RPM;
        in_ready    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (status.is_capture)
                begin
                    if (!status.armed)
                    begin
                        cmd.arm    = 1'b1;
                        state_next = S_IDLE;
                    end
                    else if (status.diff_ok)
                    begin
                        cmd.div_start = 1'b1;
                        cmd.div_sel   = DIV_RPM;
                        state_next    = S_RPM_DIV;
                    end
                    else
                    begin
                        cmd.rpm_zero = 1'b1;
                        state_next   = S_SPEED;
                    end
                end
                else if (status.frame_ok)
                begin
                    cmd.frame_dec = 1'b1;
                    state_next    = status.accel_due ? S_ACC_START : S_IDLE_UPD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_RPM_DIV:
            begin
                if (status.div_done)
                begin
                    cmd.rpm_store = 1'b1;
                    state_next    = S_SPEED;
                end
            end
            S_SPEED:
            begin
                cmd.speed_store = 1'b1;
                state_next      = S_IDLE;
            end
            S_ACC_START:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_ACCEL;
                state_next    = S_ACC_DIV;
            end
            S_ACC_DIV:
            begin
                cmd.div_sel = DIV_ACCEL;
                if (status.div_done)
                begin
                    cmd.acc_store = 1'b1;
                    state_next    = S_IDLE_UPD;
                end
            end
            S_IDLE_UPD:
            begin
                cmd.idle_upd = 1'b1;
                state_next   = S_SEC;
            end
            S_SEC:
            begin
                cmd.sec_load = 1'b1;
                state_next   = S_OUT;
            end
            S_OUT:
            begin
                if (!status.out_full)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // checks
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("controller state not one-hot");
    a_accept_decodes: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_DECODE))
        else $error("accepted item not decoded");
    a_load_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> (state_reg == S_IDLE))
        else $error("result load did not end the item");

endmodule

FILE: rtl/core/wheel_speed_sensor_telemetry.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wheel_speed_sensor_telemetry
// Wheel speed from paired timer captures and decode of sensor frames
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one item at a time: mode 0 is a timer capture, mode 1 a
//   received sensor frame. Captures pair up; the second of a pair updates rpm
//   and speed. A frame with the configured id and a length of 7 or more yields
//   one item on out_ch; captures and rejected frames yield none.
//   cfg_ch writes the seven registers by index; it is always ready and is to be
//   written only while the block is idle, which the block itself does not enforce.
// Timing:
//   the block works on one item at a time; in_ch.ready is high only when the
//   controller is idle. A second capture with a valid gap takes its 16-bit
//   quotient through the 32-step serial divider, as does a frame when the
//   acceleration is recomputed; idle seconds come from a reciprocal multiply.
// Reset and stall:
//   reset restores register defaults and clears the pairing, speed, accel,
//   idle and sequence state and the result valid flag. A result waits in the
//   output register while out_ch.ready is low; the next item is still taken and
//   stalls only when it needs to load a new result into the occupied register.
// ----------------------------------------------------------------------------
module wheel_speed_sensor_telemetry
    import wss_pkg::*;
#(
    parameter int COUNTER_BITS = COUNTER_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    wss_in_if.sink    in_ch,
    wss_out_if.source out_ch,
    wss_cfg_if.sink   cfg_ch
);

    wss_cmd_t    cmd;
    wss_status_t status;
    wss_result_t result;
    logic        in_ready;
    logic        out_valid;

    // controller
    wss_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath
    wss_dp #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .in_mode          (in_ch.mode),
        .in_capture_value (in_ch.capture_value),
        .in_frame_id      (in_ch.frame_id),
        .in_frame_length  (in_ch.frame_length),
        .in_frame_payload (in_ch.frame_payload),
        .in_now_ms        (in_ch.now_ms),
        .cfg_valid        (cfg_ch.valid),
        .cfg_index        (cfg_ch.index),
        .cfg_data         (cfg_ch.data),
        .out_valid        (out_valid),
        .out_ready        (out_ch.ready),
        .out_result       (result)
    );

    // channel hookup
    assign in_ch.ready              = in_ready;
    assign cfg_ch.ready             = 1'b1;
    assign out_ch.valid             = out_valid;
    assign out_ch.temp_tenths       = result.temp_tenths;
    assign out_ch.humidity_tenths   = result.humidity_tenths;
    assign out_ch.obstacle_state    = result.obstacle_state;
    assign out_ch.sound_level       = result.sound_level;
    assign out_ch.sequence_number   = result.sequence_number;
    assign out_ch.speed_tenths_kmh  = result.speed_tenths_kmh;
    assign out_ch.accel_tenths_mps2 = result.accel_tenths_mps2;
    assign out_ch.wheel_rpm         = result.wheel_rpm;
    assign out_ch.idle_seconds      = result.idle_seconds;
    assign out_ch.alert_flags       = result.alert_flags;

endmodule
